### design/dti_pkg.sv
// Shared types, register codes and constants of the DMRS channel time interpolator.
// No dependencies; every other design file but dti_checker.sv imports this package.
package dti_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int SYMBOL_W   = 4;
   localparam int ELEM_W     = 12;
   localparam int SLOT_W     = 2;
   localparam int POS_W      = 4;
   localparam int RSCNT_W    = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 4;
   localparam int NUM_POS    = 4;

   // Weights are unsigned Q1.15; one is 2^15.
   localparam int WEIGHT_W   = 16;
   localparam int FRAC_BITS  = 15;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1 << FRAC_BITS);

   // Rounded weight = floor(numer / den) with numer below 2^19 and den below 16,
   // done as a multiply by ceil(2^23 / den) and a shift by 23.
   localparam int NUMER_W     = POS_W + FRAC_BITS;
   localparam int RECIP_SHIFT = NUMER_W + POS_W;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int RECIP_ONE   = 1 << RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] RECIP_TABLE [16] = '{
      RECIP_W'(0),
      RECIP_W'(RECIP_ONE),
      RECIP_W'((RECIP_ONE + 1) / 2),
      RECIP_W'((RECIP_ONE + 2) / 3),
      RECIP_W'((RECIP_ONE + 3) / 4),
      RECIP_W'((RECIP_ONE + 4) / 5),
      RECIP_W'((RECIP_ONE + 5) / 6),
      RECIP_W'((RECIP_ONE + 6) / 7),
      RECIP_W'((RECIP_ONE + 7) / 8),
      RECIP_W'((RECIP_ONE + 8) / 9),
      RECIP_W'((RECIP_ONE + 9) / 10),
      RECIP_W'((RECIP_ONE + 10) / 11),
      RECIP_W'((RECIP_ONE + 11) / 12),
      RECIP_W'((RECIP_ONE + 12) / 13),
      RECIP_W'((RECIP_ONE + 13) / 14),
      RECIP_W'((RECIP_ONE + 14) / 15)
   };

   typedef logic [SYMBOL_W-1:0] symbol_type;
   typedef logic [ELEM_W-1:0]   elem_type;
   typedef logic [SLOT_W-1:0]   slot_type;
   typedef logic [POS_W-1:0]    pos_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef enum logic {
      ACT_LOAD   = 1'b0,
      ACT_INTERP = 1'b1
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_RS_COUNT = 3'd0,
      REG_POS_0    = 3'd1,
      REG_POS_1    = 3'd2,
      REG_POS_2    = 3'd3,
      REG_POS_3    = 3'd4,
      REG_BYPASS   = 3'd5
   } csr_index_type;

   typedef struct packed {
      sample_type re;
      sample_type im;
   } entry_type;

   typedef struct packed {
      logic [RSCNT_W-1:0]          rs_count;
      logic [NUM_POS-1:0][POS_W-1:0] pos;
      logic                        bypass;
   } cfg_type;

   // Neighbor choice for one symbol: the two slots and the weight fraction.
   typedef struct packed {
      slot_type slot_a;
      slot_type slot_b;
      logic     copy;
      pos_type  num;
      pos_type  den;
   } sel_type;

   typedef struct packed {
      symbol_type sym;
      elem_type   elem;
      logic       bypass;
      entry_type  raw;
      logic       copy;
      pos_type    num;
      pos_type    den;
   } s1_type;

endpackage

### design/dti_channel_if.sv
// Valid/ready channel interfaces for the request and result items.
// Depends on dti_pkg for the payload types.
interface dti_req_if;
   import dti_pkg::*;
   logic       valid;
   logic       ready;
   action_type action;
   slot_type   rs_slot;
   symbol_type symbol;
   elem_type   element;
   sample_type value_re;
   sample_type value_im;

   modport source (output valid, action, rs_slot, symbol, element, value_re, value_im,
                   input ready);
   modport sink   (input valid, action, rs_slot, symbol, element, value_re, value_im,
                   output ready);
endinterface

interface dti_rsp_if;
   import dti_pkg::*;
   logic       valid;
   logic       ready;
   symbol_type out_symbol;
   elem_type   out_element;
   sample_type interp_re;
   sample_type interp_im;

   modport source (output valid, out_symbol, out_element, interp_re, interp_im,
                   input ready);
   modport sink   (input valid, out_symbol, out_element, interp_re, interp_im,
                   output ready);
endinterface

### design/dmrs_channel_time_interpolator.sv
// Top level of the DMRS channel time interpolator: configuration registers, request stage,
// estimate store, neighbor search and blend pipeline. Depends on dti_pkg and the channel interfaces.
//
// Usage. The req_ch channel carries two kinds of item. A load item (action ACT_LOAD)
// writes one complex estimate for a DMRS slot and element into the store and gives no
// result. An interpolate item (action ACT_INTERP) names a symbol and an element and gives
// one result on rsp_ch: the linear blend of the estimates at the two DMRS symbols around
// it, or in bypass mode the item's own value. Requests with a symbol or element out of
// range are dropped without a result. Configuration is written through csr_we, csr_index
// and csr_wdata while the block is idle; indexes past the register list are ignored.
//
// Throughput is one item per cycle of either kind while the receiver does not stall. A request
// on its way to the result passes the store read, the weight multiply, the sample multiplies
// and the rounding, each in one register stage. A request right after a load of the same
// entry sees the new data, since the write lands at the edge that accepts the load.
// Reading an entry that was never loaded gives an undefined value.
//
// Reset clears the configuration to one DMRS at symbol 2 with bypass off and empties the
// pipeline; the store itself is not cleared. When the receiver stalls, the result register
// holds and the stages behind it keep filling, so req_ch.ready drops only once every stage
// holds an item.
module dmrs_channel_time_interpolator #(
   parameter int MAX_ELEMENTS     = 4096,
   parameter int MAX_RS           = 4,
   parameter int SYMBOLS_PER_SLOT = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   dti_req_if.sink                           req_ch,
   dti_rsp_if.source                         rsp_ch,
   input  logic                              csr_we,
   input  logic [dti_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dti_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import dti_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   sel_type   sel;
   s1_type    s1_ff, s1_in;
   logic      v1_ff;
   logic      en1, s1_pop;
   logic      accept, elem_ok, wr_en, is_req;
   entry_type wr_data, rd_a, rd_b;

   // Register writes; an index past the list changes nothing.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_RS_COUNT: cfg_in.rs_count = RSCNT_W'(csr_wdata);
            REG_POS_0:    cfg_in.pos[0]   = POS_W'(csr_wdata);
            REG_POS_1:    cfg_in.pos[1]   = POS_W'(csr_wdata);
            REG_POS_2:    cfg_in.pos[2]   = POS_W'(csr_wdata);
            REG_POS_3:    cfg_in.pos[3]   = POS_W'(csr_wdata);
            REG_BYPASS:   cfg_in.bypass   = csr_wdata[0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rs_count <= RSCNT_W'(1);
         cfg_ff.pos[0]   <= POS_W'(2);
         cfg_ff.pos[1]   <= '0;
         cfg_ff.pos[2]   <= '0;
         cfg_ff.pos[3]   <= '0;
         cfg_ff.bypass   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The request stage moves whenever it is empty or the blend pipeline takes its item.
   assign en1          = !v1_ff || s1_pop;
   assign req_ch.ready = en1;
   assign accept       = req_ch.valid && en1;

   assign elem_ok = 32'(req_ch.element) < MAX_ELEMENTS;
   assign wr_en   = accept && req_ch.action == ACT_LOAD &&
                    32'(req_ch.rs_slot) < MAX_RS && elem_ok;
   assign is_req  = accept && req_ch.action == ACT_INTERP &&
                    32'(req_ch.symbol) < SYMBOLS_PER_SLOT && elem_ok;

   assign wr_data.re = req_ch.value_re;
   assign wr_data.im = req_ch.value_im;

   dti_select #(
      .MAX_RS (MAX_RS)
   ) u_select (
      .cfg    (cfg_ff),
      .symbol (req_ch.symbol),
      .sel    (sel)
   );

   dti_store #(
      .MAX_RS       (MAX_RS),
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_slot   (req_ch.rs_slot),
      .elem      (req_ch.element),
      .wr_data   (wr_data),
      .rd_en     (is_req),
      .rd_slot_a (sel.slot_a),
      .rd_slot_b (sel.slot_b),
      .rd_a      (rd_a),
      .rd_b      (rd_b)
   );

   always_comb begin
      s1_in.sym    = req_ch.symbol;
      s1_in.elem   = req_ch.element;
      s1_in.bypass = cfg_ff.bypass;
      s1_in.raw    = wr_data;
      s1_in.copy   = sel.copy;
      s1_in.num    = sel.num;
      s1_in.den    = sel.den;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= is_req;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_ff <= s1_in;
      end
   end

   dti_blend u_blend (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (v1_ff),
      .s1       (s1_ff),
      .rd_a     (rd_a),
      .rd_b     (rd_b),
      .s1_pop   (s1_pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

### design/dti_store.sv
// Estimate store: one write port and two registered read ports.
// Depends on dti_pkg.
module dti_store #(
   parameter int MAX_RS       = 4,
   parameter int MAX_ELEMENTS = 4096
) (
   input  logic               clock,
   input  logic               wr_en,
   input  dti_pkg::slot_type  wr_slot,
   input  dti_pkg::elem_type  elem,
   input  dti_pkg::entry_type wr_data,
   input  logic               rd_en,
   input  dti_pkg::slot_type  rd_slot_a,
   input  dti_pkg::slot_type  rd_slot_b,
   output dti_pkg::entry_type rd_a,
   output dti_pkg::entry_type rd_b
);
   import dti_pkg::*;

   localparam int DEPTH = MAX_RS * MAX_ELEMENTS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   entry_type mem [DEPTH];
   entry_type rd_a_ff;
   entry_type rd_b_ff;

   function automatic logic [AW-1:0] entry_addr(slot_type s, elem_type e);
      return AW'(32'(s) * MAX_ELEMENTS + 32'(e));
   endfunction

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[entry_addr(wr_slot, elem)] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[entry_addr(rd_slot_a, elem)];
         rd_b_ff <= mem[entry_addr(rd_slot_b, elem)];
      end
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

### design/dti_select.sv
// Neighbor search: picks the DMRS slots around a symbol and the weight fraction.
// Depends on dti_pkg.
module dti_select #(
   parameter int MAX_RS = 4
) (
   input  dti_pkg::cfg_type    cfg,
   input  dti_pkg::symbol_type symbol,
   output dti_pkg::sel_type    sel
);
   import dti_pkg::*;

   logic [RSCNT_W-1:0] n_rs;
   slot_type           last_slot;
   pos_type            sym_pos;
   logic               found;

   always_comb begin
      n_rs = cfg.rs_count;
      if (n_rs == '0) begin
         n_rs = RSCNT_W'(1);
      end else if (32'(n_rs) > MAX_RS) begin
         n_rs = RSCNT_W'(MAX_RS);
      end
   end

   assign last_slot = SLOT_W'(n_rs - RSCNT_W'(1));
   assign sym_pos   = POS_W'(symbol);

   always_comb begin
      sel.slot_a = '0;
      sel.slot_b = '0;
      sel.copy   = 1'b1;
      sel.num    = '0;
      sel.den    = '0;
      found      = 1'b0;
      if (n_rs == RSCNT_W'(1) || sym_pos <= cfg.pos[0]) begin
         found = 1'b1;
      end else if (sym_pos >= cfg.pos[last_slot]) begin
         sel.slot_a = last_slot;
         sel.slot_b = last_slot;
         found      = 1'b1;
      end
      // Scan the pairs in order; the first pair that brackets the symbol wins.
      for (int i = 0; i < MAX_RS - 1; i++) begin
         if (!found && (i + 1) < 32'(n_rs) &&
             sym_pos >= cfg.pos[i] && sym_pos <= cfg.pos[i+1]) begin
            found      = 1'b1;
            sel.slot_a = SLOT_W'(i);
            if (cfg.pos[i+1] > cfg.pos[i]) begin
               sel.slot_b = SLOT_W'(i + 1);
               sel.copy   = 1'b0;
               sel.num    = cfg.pos[i+1] - sym_pos;
               sel.den    = cfg.pos[i+1] - cfg.pos[i];
            end else begin
               sel.slot_b = SLOT_W'(i);
            end
         end
      end
   end

endmodule

### design/dti_blend.sv
// Weight, multiply and round stages that follow the store read, plus the result register.
// Depends on dti_pkg and the dti_rsp_if interface.
module dti_blend (
   input  logic               clock,
   input  logic               reset,
   input  logic               s1_valid,
   input  dti_pkg::s1_type    s1,
   input  dti_pkg::entry_type rd_a,
   input  dti_pkg::entry_type rd_b,
   output logic               s1_pop,
   dti_rsp_if.source          rsp_ch
);
   import dti_pkg::*;

   localparam int PRD_W  = NUMER_W + RECIP_W;
   localparam int MUL_W  = WEIGHT_W + 1 + SAMPLE_W;
   localparam int SUM_W  = MUL_W + 1;
   localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1 << (FRAC_BITS - 1));

   typedef struct packed {
      symbol_type               sym;
      elem_type                 elem;
      logic                     bypass;
      entry_type                raw;
      logic [WEIGHT_W-1:0]      wa;
      entry_type                ha;
      entry_type                hb;
   } s2_type;

   typedef struct packed {
      symbol_type               sym;
      elem_type                 elem;
      logic                     bypass;
      entry_type                raw;
      logic signed [MUL_W-1:0]  re_a;
      logic signed [MUL_W-1:0]  re_b;
      logic signed [MUL_W-1:0]  im_a;
      logic signed [MUL_W-1:0]  im_b;
   } s3_type;

   logic      v2_ff, v3_ff, out_v_ff;
   s2_type    s2_ff, s2_in;
   s3_type    s3_ff, s3_in;
   logic      take2, take3, take_out;

   logic [NUMER_W-1:0]       numer;
   logic [PRD_W-1:0]         wa_prod;
   logic [WEIGHT_W-1:0]      wb;
   logic signed [SUM_W-1:0]  sum_re, sum_im;
   symbol_type               out_sym_ff;
   elem_type                 out_elem_ff;
   entry_type                out_val_ff, out_val_in;

   assign take_out = !out_v_ff || rsp_ch.ready;
   assign take3    = !v3_ff || take_out;
   assign take2    = !v2_ff || take3;
   assign s1_pop   = take2;

   // Left weight = round(num * 2^15 / den) through the reciprocal table.
   assign numer   = {s1.num, FRAC_BITS'(0)} + NUMER_W'(s1.den >> 1);
   assign wa_prod = PRD_W'(numer) * PRD_W'(RECIP_TABLE[s1.den]);

   always_comb begin
      s2_in.sym    = s1.sym;
      s2_in.elem   = s1.elem;
      s2_in.bypass = s1.bypass;
      s2_in.raw    = s1.raw;
      s2_in.wa     = s1.copy ? WEIGHT_ONE : wa_prod[RECIP_SHIFT +: WEIGHT_W];
      s2_in.ha     = rd_a;
      s2_in.hb     = rd_b;
   end

   assign wb = WEIGHT_ONE - s2_ff.wa;

   always_comb begin
      s3_in.sym    = s2_ff.sym;
      s3_in.elem   = s2_ff.elem;
      s3_in.bypass = s2_ff.bypass;
      s3_in.raw    = s2_ff.raw;
      s3_in.re_a   = MUL_W'($signed({1'b0, s2_ff.wa}) * s2_ff.ha.re);
      s3_in.re_b   = MUL_W'($signed({1'b0, wb}) * s2_ff.hb.re);
      s3_in.im_a   = MUL_W'($signed({1'b0, s2_ff.wa}) * s2_ff.ha.im);
      s3_in.im_b   = MUL_W'($signed({1'b0, wb}) * s2_ff.hb.im);
   end

   // The arithmetic shift gives floor division by 2^15, negative sums included.
   assign sum_re = SUM_W'(s3_ff.re_a) + SUM_W'(s3_ff.re_b) + ROUND_HALF;
   assign sum_im = SUM_W'(s3_ff.im_a) + SUM_W'(s3_ff.im_b) + ROUND_HALF;

   always_comb begin
      if (s3_ff.bypass) begin
         out_val_in = s3_ff.raw;
      end else begin
         out_val_in.re = sum_re[FRAC_BITS +: SAMPLE_W];
         out_val_in.im = sum_im[FRAC_BITS +: SAMPLE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (take2) begin
            v2_ff <= s1_valid;
         end
         if (take3) begin
            v3_ff <= v2_ff;
         end
         if (take_out) begin
            out_v_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take2) begin
         s2_ff <= s2_in;
      end
      if (take3) begin
         s3_ff <= s3_in;
      end
      if (take_out) begin
         out_sym_ff  <= s3_ff.sym;
         out_elem_ff <= s3_ff.elem;
         out_val_ff  <= out_val_in;
      end
   end

   assign rsp_ch.valid       = out_v_ff;
   assign rsp_ch.out_symbol  = out_sym_ff;
   assign rsp_ch.out_element = out_elem_ff;
   assign rsp_ch.interp_re   = out_val_ff.re;
   assign rsp_ch.interp_im   = out_val_ff.im;

endmodule

### design/dti_checker.sv
// Port-level assertions for the DMRS channel time interpolator and the bind that attaches them.
// Depends on the top level's ports only.
module dti_checker #(
   parameter int SYMBOLS_PER_SLOT = 14
) (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_symbol,
   input logic [11:0] rsp_element,
   input logic [15:0] rsp_re,
   input logic [15:0] rsp_im
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_symbol) && $stable(rsp_element) &&
                                  $stable(rsp_re) && $stable(rsp_im))
      else $error("result item changed while stalled");

   // With no result waiting, every stage can drain, so the input must be open.
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with the result register empty");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_symbol_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_symbol) < SYMBOLS_PER_SLOT)
      else $error("result for an out-of-range symbol");

endmodule

bind dmrs_channel_time_interpolator dti_checker #(
   .SYMBOLS_PER_SLOT (SYMBOLS_PER_SLOT)
) u_dti_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_symbol  (rsp_ch.out_symbol),
   .rsp_element (rsp_ch.out_element),
   .rsp_re      (rsp_ch.interp_re),
   .rsp_im      (rsp_ch.interp_im)
);
